/* src/sfrx_pkg.sv */
// shared types and constants for the serial frame receiver
// no dependencies; imported by sfrx_core, serial_frame_receiver_xor and the testbench
`timescale 1ns / 1ps

package sfrx_pkg;

    // smallest legal length byte (receiver plus checksum)
    localparam logic [7:0]  MIN_LEN       = 8'd2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd50;

    // item kinds on the input side
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SUM  = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    // receive phases, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_RECV = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    // one result from the frame engine
    typedef struct packed {
        logic       valid;
        logic       frame_end;
        logic [7:0] sender_addr;
        logic [7:0] receiver_addr;
        logic [7:0] data_byte;
        logic [7:0] payload_count;
        logic [1:0] status;
    } result_t;

endpackage

/* src/sfrx_core.sv */
// frame engine: phase, addresses, running xor and counters for one stream
// depends on sfrx_pkg
`timescale 1ns / 1ps

module sfrx_core
    import sfrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] timeout_ticks,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  sender_reg, sender_next;
    logic [7:0]  receiver_reg, receiver_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] tick_inc;
    logic [7:0]  count_inc;

    assign tick_inc  = tick_reg + 16'd1;
    assign count_inc = count_reg + 8'd1;

    // next state and result for the item in the input register
    always_comb
    begin
        phase_next    = phase_reg;
        sender_next   = sender_reg;
        receiver_next = receiver_reg;
        left_next     = left_reg;
        xor_next      = xor_reg;
        count_next    = count_reg;
        tick_next     = tick_reg;

        res.valid         = 1'b0;
        res.frame_end     = 1'b1;
        res.sender_addr   = sender_reg;
        res.receiver_addr = receiver_reg;
        res.data_byte     = 8'd0;
        res.payload_count = count_reg;
        res.status        = ST_OK;

        if (step)
        begin
            if (action == ACT_TICK)
            begin
                // ticks only count once the length is in
                if (phase_reg == PH_RECV || phase_reg == PH_DATA)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= timeout_ticks)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_TIMEOUT;
                        phase_next = PH_IDLE;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        sender_next   = rx_byte;
                        receiver_next = 8'd0;
                        count_next    = 8'd0;
                        xor_next      = rx_byte;
                        phase_next    = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (rx_byte < MIN_LEN)
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_BAD_LEN;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            left_next  = rx_byte;
                            xor_next   = xor_reg ^ rx_byte;
                            tick_next  = 16'd0;
                            phase_next = PH_RECV;
                        end
                    end
                    PH_RECV:
                    begin
                        receiver_next = rx_byte;
                        xor_next      = xor_reg ^ rx_byte;
                        left_next     = left_reg - 8'd1;
                        phase_next    = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        res.valid = 1'b1;
                        if (left_reg <= 8'd1)
                        begin
                            // checksum byte closes the frame
                            res.status = (rx_byte == xor_reg) ? ST_OK : ST_BAD_SUM;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            xor_next          = xor_reg ^ rx_byte;
                            count_next        = count_inc;
                            left_next         = left_reg - 8'd1;
                            res.frame_end     = 1'b0;
                            res.data_byte     = rx_byte;
                            res.payload_count = count_inc;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            sender_reg   <= 8'd0;
            receiver_reg <= 8'd0;
            left_reg     <= 8'd0;
            xor_reg      <= 8'd0;
            count_reg    <= 8'd0;
            tick_reg     <= 16'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            sender_reg   <= sender_next;
            receiver_reg <= receiver_next;
            left_reg     <= left_next;
            xor_reg      <= xor_next;
            count_reg    <= count_next;
            tick_reg     <= tick_next;
        end
    end

endmodule

/* src/serial_frame_receiver_xor.sv */
// serial frame receiver with xor checksum: input register, frame engine, result register
// the frame engine update between the input register and the result register is
// combinational; one item per cycle sustained while results are taken, and a result
// held by m_tready low stalls s_tready
// reset: rst_n async active low; idle awaiting sender, counters zero, timeout 50 ticks
// depends on sfrx_pkg and sfrx_core
`timescale 1ns / 1ps

module serial_frame_receiver_xor
    import sfrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: timeout_ticks
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tuser,    // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] sender_addr, [15:8] receiver_addr,
                                    // [23:16] data_byte, [31:24] payload_count,
                                    // [33:32] status, [39:34] zero
    output logic        m_tlast     // frame_end
);

    logic [15:0] timeout_reg;
    logic        in_valid_reg;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     res;
    logic        advance;

    // the input register moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    sfrx_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .action        (in_action_reg),
        .rx_byte       (in_byte_reg),
        .timeout_ticks (timeout_reg),
        .res           (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_reg <= res;
        end
    end

    // result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.frame_end;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.payload_count, out_reg.data_byte,
                       out_reg.receiver_addr, out_reg.sender_addr};

endmodule

/* verif/tb_serial_frame_receiver_xor.sv */
// self-checking testbench for serial_frame_receiver_xor: stream driver, result monitor,
// frame predictor, directed frames, then random frames under four handshake modes
// depends on sfrx_pkg and serial_frame_receiver_xor
`timescale 1ns / 1ps

module tb_serial_frame_receiver_xor;
    import sfrx_pkg::*;

    // one input item and one predicted result
    typedef struct {
        logic       action;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct {
        logic       frame_end;
        logic [7:0] sender_addr;
        logic [7:0] receiver_addr;
        logic [7:0] data_byte;
        logic [7:0] payload_count;
        logic [1:0] status;
    } frame_result_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [15:0] cfg_wr_data  = 16'd0;
    logic        s_tvalid     = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata      = 8'd0;    // [7:0] rx_byte
    logic        s_tuser      = 1'b0;    // [0] action
    logic        m_tvalid;
    logic        m_tready     = 1'b0;
    logic [39:0] m_tdata;                // [7:0] sender, [15:8] receiver, [23:16] data,
                                         // [31:24] payload count, [33:32] status
    logic        m_tlast;                // frame_end

    rx_item_t      pending_items[$];
    frame_result_t expected_results[$];
    rx_item_t      drive_item;
    frame_result_t want;

    int src_idle_pct     = 0;
    int sink_stall_pct   = 0;
    int mismatch_count   = 0;
    int items_accepted   = 0;
    int results_checked  = 0;
    int frame_ends_seen  = 0;
    int queued_count     = 0;

    // predictor state
    phase_t      rx_phase        = PH_IDLE;
    logic [7:0]  frame_sender    = 8'd0;
    logic [7:0]  frame_receiver  = 8'd0;
    logic [7:0]  bytes_remaining = 8'd0;
    logic [7:0]  frame_xor       = 8'd0;
    logic [7:0]  payload_total   = 8'd0;
    logic [15:0] ticks_since_len = 16'd0;
    logic [15:0] timeout_limit   = TIMEOUT_RESET;

    serial_frame_receiver_xor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // queue a frame-end or payload result from the current frame registers
    task automatic push_result(input logic is_end, input logic [7:0] data,
                               input logic [1:0] st);
        frame_result_t r;
        r.frame_end     = is_end;
        r.sender_addr   = frame_sender;
        r.receiver_addr = frame_receiver;
        r.data_byte     = data;
        r.payload_count = payload_total;
        r.status        = st;
        expected_results.push_back(r);
    endtask

    // advance the frame predictor by one accepted item
    task automatic predict_item(input logic act, input logic [7:0] b);
        if (act == ACT_TICK)
        begin
            // ticks only count once the length byte is in
            if (rx_phase == PH_RECV || rx_phase == PH_DATA)
            begin
                ticks_since_len = ticks_since_len + 16'd1;
                if (ticks_since_len >= timeout_limit)
                begin
                    push_result(1'b1, 8'd0, ST_TIMEOUT);
                    rx_phase = PH_IDLE;
                end
            end
        end
        else
        begin
            case (rx_phase)
                PH_IDLE:
                begin
                    frame_sender   = b;
                    frame_receiver = 8'd0;
                    payload_total  = 8'd0;
                    frame_xor      = b;
                    rx_phase       = PH_LEN;
                end
                PH_LEN:
                begin
                    if (b < MIN_LEN)
                    begin
                        push_result(1'b1, 8'd0, ST_BAD_LEN);
                        rx_phase = PH_IDLE;
                    end
                    else
                    begin
                        bytes_remaining = b;
                        frame_xor       = frame_xor ^ b;
                        ticks_since_len = 16'd0;
                        rx_phase        = PH_RECV;
                    end
                end
                PH_RECV:
                begin
                    frame_receiver  = b;
                    frame_xor       = frame_xor ^ b;
                    bytes_remaining = bytes_remaining - 8'd1;
                    rx_phase        = PH_DATA;
                end
                PH_DATA:
                begin
                    // last byte of the frame is the checksum
                    if (bytes_remaining <= 8'd1)
                    begin
                        push_result(1'b1, 8'd0, (b == frame_xor) ? ST_OK : ST_BAD_SUM);
                        rx_phase = PH_IDLE;
                    end
                    else
                    begin
                        frame_xor       = frame_xor ^ b;
                        payload_total   = payload_total + 8'd1;
                        bytes_remaining = bytes_remaining - 8'd1;
                        push_result(1'b0, b, ST_OK);
                    end
                end
                default: rx_phase = PH_IDLE;
            endcase
        end
    endtask

    // input driver: predicts each transfer at the edge that takes it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_item(s_tuser, s_tdata);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    drive_item = pending_items.pop_front();
                    s_tvalid   <= 1'b1;
                    s_tuser    <= drive_item.action;
                    s_tdata    <= drive_item.rx_byte;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            mismatch_count++;
        end
    endfunction

    // result monitor with random backpressure
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: tdata %h tlast %b",
                       m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("frame_end", {7'd0, want.frame_end}, {7'd0, m_tlast});
                check_field("sender_addr", want.sender_addr, m_tdata[7:0]);
                check_field("receiver_addr", want.receiver_addr, m_tdata[15:8]);
                check_field("data_byte", want.data_byte, m_tdata[23:16]);
                check_field("payload_count", want.payload_count, m_tdata[31:24]);
                check_field("status", {6'd0, want.status}, {6'd0, m_tdata[33:32]});
                results_checked++;
                if (want.frame_end)
                    frame_ends_seen++;
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // stimulus helpers
    task automatic push_item(input logic act, input logic [7:0] b);
        rx_item_t it;
        it.action  = act;
        it.rx_byte = b;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic maybe_tick(input int tick_pct);
        if ($urandom_range(99) < tick_pct)
            push_item(ACT_TICK, 8'($urandom_range(255)));
    endtask

    // whole frame with random addresses and payload, checksum optionally broken
    task automatic queue_frame(input int len, input bit corrupt, input int tick_pct);
        logic [7:0] sum;
        logic [7:0] b;
        int i;
        maybe_tick(tick_pct);
        b = 8'($urandom_range(255));
        push_item(ACT_BYTE, b);
        sum = b;
        maybe_tick(tick_pct);
        push_item(ACT_BYTE, len[7:0]);
        sum = sum ^ len[7:0];
        maybe_tick(tick_pct);
        b = 8'($urandom_range(255));
        push_item(ACT_BYTE, b);
        sum = sum ^ b;
        for (i = 0; i < len - 2; i++)
        begin
            maybe_tick(tick_pct);
            b = 8'($urandom_range(255));
            push_item(ACT_BYTE, b);
            sum = sum ^ b;
        end
        maybe_tick(tick_pct);
        if (corrupt)
            sum = sum ^ (8'h01 << $urandom_range(7));
        push_item(ACT_BYTE, sum);
    endtask

    // let the block drain; frames with no result may still be in flight
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        timeout_limit = value;
    endtask

    // mostly well-formed frames, some bad lengths, truncations and noise
    task automatic random_traffic(input int budget, input int tick_pct);
        int sel;
        int n;
        int i;
        int start_count;
        start_count = queued_count;
        while (queued_count - start_count < budget)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(2, 255) : $urandom_range(2, 12);
                queue_frame(n, $urandom_range(4) == 0, tick_pct);
            end
            else if (sel < 80)
            begin
                push_item(ACT_BYTE, 8'($urandom_range(255)));
                push_item(ACT_BYTE, 8'($urandom_range(1)));
            end
            else if (sel < 90)
            begin
                push_item(ACT_BYTE, 8'($urandom_range(255)));
                push_item(ACT_BYTE, 8'($urandom_range(3, 12)));
                n = $urandom_range(0, 2);
                for (i = 0; i < n; i++)
                    push_item(ACT_BYTE, 8'($urandom_range(255)));
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    // main sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_timeout(16'd3);

        // directed: ignored ticks, both bad lengths, empty payload,
        // extreme payload bytes with a bad checksum, timeout
        push_item(ACT_TICK, 8'hFF);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_TICK, 8'h00);
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'h01);
        push_item(ACT_BYTE, 8'h12);
        push_item(ACT_BYTE, 8'h02);
        push_item(ACT_BYTE, 8'h34);
        push_item(ACT_BYTE, 8'h12 ^ 8'h02 ^ 8'h34);
        push_item(ACT_BYTE, 8'hA5);
        push_item(ACT_BYTE, 8'h04);
        push_item(ACT_BYTE, 8'h5A);
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_BYTE, 8'hA5 ^ 8'h04 ^ 8'h5A ^ 8'hFF ^ 8'h80);
        push_item(ACT_BYTE, 8'h01);
        push_item(ACT_BYTE, 8'h03);
        push_item(ACT_BYTE, 8'h80);
        push_item(ACT_TICK, 8'h55);
        push_item(ACT_TICK, 8'hAA);
        push_item(ACT_TICK, 8'h00);
        wait_drained();

        // no idling, longest timeout, a full-size frame and a frame left open
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_timeout(16'hFFFF);
        queue_frame(255, 1'b0, 5);
        random_traffic(100, 10);
        push_item(ACT_BYTE, 8'hC3);
        push_item(ACT_BYTE, 8'd200);
        push_item(ACT_BYTE, 8'h3C);
        push_item(ACT_TICK, 8'h11);
        push_item(ACT_TICK, 8'h22);
        push_item(ACT_BYTE, 8'h77);
        push_item(ACT_TICK, 8'h00);
        wait_drained();

        // sender idling, every counted tick aborts the frame
        src_idle_pct   = 63;
        sink_stall_pct = 0;
        write_timeout(16'd1);
        random_traffic(150, 3);
        wait_drained();

        // receiver stalling, short random timeout
        src_idle_pct   = 0;
        sink_stall_pct = 63;
        write_timeout(16'($urandom_range(2, 40)));
        random_traffic(150, 15);
        wait_drained();

        // both sides idling
        src_idle_pct   = 29;
        sink_stall_pct = 29;
        write_timeout(16'd2);
        random_traffic(150, 5);
        wait_drained();

        repeat (10) @(posedge clk);
        $display("covered %0d input transfers and %0d result transfers (%0d frame ends)",
                 items_accepted, results_checked, frame_ends_seen);
        $display("timeouts 1 to 65535, bad lengths, bad checksums, four handshake modes");
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
